@@ hw/rtl/xor_checked_frame_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared check macros for the frame deframer.
// ---------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define XCFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another in the following cycle.
`define XCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/xcfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Frame deframer package
// Types and constants shared by the deframer modules.
// ---------------------------------------------------------------------------
package xcfd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_CMD_HI = 3'd3,
    PH_CMD_LO = 3'd4,
    PH_BODY   = 3'd5
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHECK = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;

  localparam logic [15:0] MIN_FRAME = 16'd6;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] command;
    logic [15:0] frame_length;
    logic [7:0]  computed_check;
    logic [7:0]  received_check;
  } res_t;

endpackage

@@ hw/rtl/xor_checked_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// XOR-checked frame deframer
// Finds header-framed packets in a byte stream and reports one status word
// per frame.
// ---------------------------------------------------------------------------
// The in_ channel carries one received byte per word. A frame starts with a
// byte equal to the configured header, followed by a big-endian total length,
// a big-endian command and the body; its last byte must equal the inverted
// XOR of all bytes before it. A status word leaves on the out_ channel at the
// end of each frame, or as soon as a length outside 6 to MAX_FRAME is seen.
// The header value is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce. One byte
// is taken every cycle while the skid stage is empty; the per-byte state update
// is a single register-to-register step. A result is valid on the out_ channel
// once it reaches the output register. Reset clears the header to zero and
// returns to header hunting. When the receiver stalls, one result waits in the
// output register, one more in the skid stage and one byte in the input
// register; after that in_tready drops until the receiver takes a word.
// ---------------------------------------------------------------------------
`include "xor_checked_frame_deframer_defines.svh"

module xor_checked_frame_deframer #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [1:0] status, [17:2] command,
                                  // [33:18] frame_length, [41:34] computed_check,
                                  // [49:42] received_check, [55:50] zero
);
  import xcfd_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res_data;
  res_t out_data;

  xcfd_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  xcfd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_data)
  );

  assign out_tdata = {6'b000000, out_data.received_check, out_data.computed_check,
                      out_data.frame_length, out_data.command, out_data.status};

  `XCFD_ASSERT_SAME(a_ok_matches, clk, rst_n,
    out_tvalid && out_data.status == ST_OK,
    out_data.computed_check == out_data.received_check,
    "ok status with differing check bytes")
  `XCFD_ASSERT_SAME(a_bad_check_differs, clk, rst_n,
    out_tvalid && out_data.status == ST_BAD_CHECK,
    out_data.computed_check != out_data.received_check,
    "checksum error with matching check bytes")
  `XCFD_ASSERT_SAME(a_bad_len_fields, clk, rst_n,
    out_tvalid && out_data.status == ST_BAD_LEN,
    out_data.command == 16'h0000 && out_data.computed_check == 8'h00
      && out_data.received_check == 8'h00,
    "length error with nonzero frame fields")
  `XCFD_ASSERT_NEXT(a_stall_blocks_input, clk, rst_n,
    res_valid && !res_ready,
    1'b0,
    "result produced while output stage full")

endmodule

@@ hw/rtl/xcfd_parser.sv @@
// ---------------------------------------------------------------------------
// Frame parser
// Input byte register, frame state and the per-byte state update.
// ---------------------------------------------------------------------------
module xcfd_parser #(
  parameter int MAX_FRAME = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic          res_ready,
  output logic          res_valid,
  output xcfd_pkg::res_t res_data
);
  import xcfd_pkg::*;

  localparam logic [15:0] MaxLen = 16'(MAX_FRAME);

  logic [7:0]  header_byte_r;
  logic [7:0]  byte_r;
  logic        vld_r, vld_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        advance;
  logic        emit;
  logic [15:0] len_full;
  logic [7:0]  calc;
  logic [16:0] pos_plus1;

  assign advance   = vld_r && res_ready;
  assign in_tready = !vld_r || advance;
  assign vld_nxt   = (in_tvalid && in_tready) || (vld_r && !advance);
  assign len_full  = {len_r[15:8], byte_r};
  assign calc      = ~xor_r;
  assign pos_plus1 = {1'b0, pos_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    xor_nxt   = xor_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    res_data  = '0;
    unique case (phase_r)
      PH_LEN_HI: begin
        len_nxt   = {byte_r, 8'h00};
        xor_nxt   = xor_r ^ byte_r;
        pos_nxt   = 16'd2;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = len_full;
        xor_nxt   = xor_r ^ byte_r;
        pos_nxt   = 16'd3;
        phase_nxt = PH_CMD_HI;
        if (len_full < MIN_FRAME || len_full > MaxLen) begin
          emit                  = 1'b1;
          res_data.status       = ST_BAD_LEN;
          res_data.frame_length = len_full;
          phase_nxt             = PH_HUNT;
        end
      end
      PH_CMD_HI: begin
        cmd_nxt   = {byte_r, 8'h00};
        xor_nxt   = xor_r ^ byte_r;
        pos_nxt   = 16'd4;
        phase_nxt = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        cmd_nxt   = {cmd_r[15:8], byte_r};
        xor_nxt   = xor_r ^ byte_r;
        pos_nxt   = 16'd5;
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (pos_plus1 == {1'b0, len_r}) begin
          emit                    = 1'b1;
          res_data.status         = (byte_r == calc) ? ST_OK : ST_BAD_CHECK;
          res_data.command        = cmd_r;
          res_data.frame_length   = len_r;
          res_data.computed_check = calc;
          res_data.received_check = byte_r;
          phase_nxt               = PH_HUNT;
        end else begin
          xor_nxt = xor_r ^ byte_r;
          pos_nxt = pos_plus1[15:0];
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (byte_r == header_byte_r) begin
          xor_nxt   = byte_r;
          pos_nxt   = 16'd1;
          phase_nxt = PH_LEN_HI;
        end
      end
    endcase
  end

  assign res_valid = advance && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= 8'h00;
      vld_r         <= 1'b0;
      phase_r       <= PH_HUNT;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        header_byte_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
    if (advance) begin
      len_r <= len_nxt;
      cmd_r <= cmd_nxt;
      xor_r <= xor_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ hw/rtl/xcfd_out_reg.sv @@
// ---------------------------------------------------------------------------
// Result register
// Output register with a skid stage so the parser keeps running while a
// result waits to be taken.
// ---------------------------------------------------------------------------
module xcfd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  xcfd_pkg::res_t res_data,
  output logic           out_valid,
  input  logic           out_ready,
  output xcfd_pkg::res_t out_data
);
  import xcfd_pkg::*;

  res_t head_r;
  res_t skid_r;
  logic head_vld_r;
  logic skid_vld_r;

  assign res_ready = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!head_vld_r || out_ready) begin
      head_vld_r <= skid_vld_r || res_valid;
      skid_vld_r <= 1'b0;
    end else if (res_valid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_vld_r || out_ready) begin
      head_r <= skid_vld_r ? skid_r : res_data;
    end else if (res_valid && !skid_vld_r) begin
      skid_r <= res_data;
    end
  end

endmodule
